@@ hdl/rht_pkg.sv @@
// Package for the retransmit history table: field widths, parameter
// defaults, the operation code, the controller state and the result word.
// No dependencies.
package rht_pkg;

  localparam int unsigned SEQ_W           = 16;
  localparam int unsigned LEN_W           = 11;
  localparam int unsigned BKT_OUT_W       = 6;
  localparam int unsigned WAY_OUT_W       = 2;

  localparam int unsigned BUCKETS_DEF     = 64;
  localparam int unsigned WAYS_DEF        = 4;
  localparam int unsigned MAX_PAYLOAD_DEF = 1024;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_MUL,
    ST_DIV_SUB,
    ST_DIV_FIX,
    ST_EXEC
  } state_e;

  // One result word as it leaves the row logic
  typedef struct packed {
    logic                 hit;
    logic [WAY_OUT_W-1:0] way;
    logic [LEN_W-1:0]     len;
  } rht_res_t;

endpackage

@@ hdl/rht_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
// Contents are undefined until written. No dependencies.
module rht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/rht_row_logic.sv @@
// Per-bucket row logic: way compare for lookup, round-robin insert and
// the updated row for write-back. Depends on rht_pkg.
module rht_row_logic #(
  parameter int unsigned WAYS        = rht_pkg::WAYS_DEF,
  parameter int unsigned MAX_PAYLOAD = rht_pkg::MAX_PAYLOAD_DEF,
  localparam int unsigned WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1,
  localparam int unsigned ROW_W      = WAYS * (rht_pkg::SEQ_W + rht_pkg::LEN_W) + WAY_W
) (
  input  rht_pkg::op_e                 op_i,
  input  logic [rht_pkg::SEQ_W-1:0]    seq_num_i,
  input  logic [rht_pkg::LEN_W-1:0]    payload_len_i,
  input  logic [ROW_W-1:0]             row_i,
  input  logic [WAYS-1:0]              valid_i,
  output rht_pkg::rht_res_t            res_o,
  output logic [ROW_W-1:0]             row_o,
  output logic [WAY_W-1:0]             wr_way_o
);
  import rht_pkg::*;

  localparam int unsigned TAG_BASE = 0;
  localparam int unsigned LEN_BASE = WAYS * SEQ_W;
  localparam int unsigned PTR_BASE = WAYS * (SEQ_W + LEN_W);
  localparam int unsigned CAP_W    = 17;

  logic [WAY_W-1:0] ptr;
  logic [WAY_W-1:0] ptr_next;
  logic [LEN_W-1:0] clamped_len;
  logic             hit_l;
  logic [WAY_W-1:0] way_l;
  logic [LEN_W-1:0] len_l;
  logic [31:0]      way_ext;

  // A bucket never written holds no valid way, so its pointer reads as zero
  assign ptr = (|valid_i) ? row_i[PTR_BASE +: WAY_W] : '0;

  always_comb begin
    if (ptr == WAY_W'(WAYS - 1)) begin
      ptr_next = '0;
    end else begin
      ptr_next = ptr + WAY_W'(1);
    end
  end

  // Saturate oversized lengths
  always_comb begin
    if ({{(CAP_W - LEN_W){1'b0}}, payload_len_i} > CAP_W'(MAX_PAYLOAD)) begin
      clamped_len = LEN_W'(MAX_PAYLOAD);
    end else begin
      clamped_len = payload_len_i;
    end
  end

  // Highest-numbered matching way wins
  always_comb begin
    hit_l = 1'b0;
    way_l = '0;
    len_l = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (valid_i[w] && row_i[TAG_BASE + w*SEQ_W +: SEQ_W] == seq_num_i) begin
        hit_l = 1'b1;
        way_l = WAY_W'(w);
        len_l = row_i[LEN_BASE + w*LEN_W +: LEN_W];
      end
    end
  end

  always_comb begin
    row_o = row_i;
    for (int w = 0; w < WAYS; w++) begin
      if (ptr == WAY_W'(w)) begin
        row_o[TAG_BASE + w*SEQ_W +: SEQ_W] = seq_num_i;
        row_o[LEN_BASE + w*LEN_W +: LEN_W] = clamped_len;
      end
    end
    row_o[PTR_BASE +: WAY_W] = ptr_next;
  end

  assign wr_way_o = ptr;

  always_comb begin
    if (op_i == OP_LOOKUP) begin
      way_ext   = 32'(way_l);
      res_o.hit = hit_l;
      res_o.len = len_l;
    end else begin
      way_ext   = 32'(ptr);
      res_o.hit = 1'b0;
      res_o.len = clamped_len;
    end
    res_o.way = way_ext[WAY_OUT_W-1:0];
  end

endmodule

@@ hdl/retransmit_history_table.sv @@
// Retransmit history table. Pulse start with op_i/seq_num_i/payload_len_i
// while busy is low; exactly one result follows on done_o, held for one
// cycle only and never stalled, so the receiver must take it when it comes.
// With a power-of-two bucket count an operation is a row read, then a
// compare or write-back; busy drops as the result cycle begins, so the
// next start is taken at the edge that ends the result cycle. With any other
// bucket count the bucket index is first formed by a reciprocal multiply,
// a subtract and a correction (ST_DIV_MUL, ST_DIV_SUB, ST_DIV_FIX). The
// bucket rows (tags, lengths, round-robin pointer) sit in one RAM; valid
// marks are flip-flops cleared at reset, so no clearing pass is needed.
// Depends on rht_pkg, rht_ram and rht_row_logic.
module retransmit_history_table #(
  parameter int unsigned BUCKETS     = rht_pkg::BUCKETS_DEF,
  parameter int unsigned WAYS        = rht_pkg::WAYS_DEF,
  parameter int unsigned MAX_PAYLOAD = rht_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          op_i,
  input  logic [rht_pkg::SEQ_W-1:0]     seq_num_i,
  input  logic [rht_pkg::LEN_W-1:0]     payload_len_i,
  output logic                          done_o,
  output logic                          hit_o,
  output logic [rht_pkg::BKT_OUT_W-1:0] slot_bucket_o,
  output logic [rht_pkg::WAY_OUT_W-1:0] slot_way_o,
  output logic [rht_pkg::LEN_W-1:0]     stored_len_o
);
  import rht_pkg::*;

  localparam int unsigned BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned ROW_W = WAYS * (SEQ_W + LEN_W) + WAY_W;
  localparam bit          POW2  = (BUCKETS > 1) && ((BUCKETS & (BUCKETS - 1)) == 0);
  // floor(2^31 / BUCKETS): quotient estimate is low by at most one
  localparam longint unsigned RECIP = (64'd1 << 31) / BUCKETS;
  localparam int unsigned PROD_W = SEQ_W + 32;
  localparam int unsigned REM_W  = BKT_W + 1;

  state_e state_q, state_d;

  logic             op_q;
  logic [SEQ_W-1:0] seq_q;
  logic [LEN_W-1:0] len_q;
  logic [BKT_W-1:0] bucket_q, bucket_d;

  logic [PROD_W-1:0] prod_q;
  logic [REM_W-1:0]  rem_q;
  logic [SEQ_W-1:0]  quot;
  logic [31:0]       quot_mul;
  logic [31:0]       rem_full;
  logic [BKT_W-1:0]  rem_fixed;

  logic [WAYS-1:0] valid_q [BUCKETS];

  logic             ram_re;
  logic [BKT_W-1:0] ram_raddr;
  logic             ram_we;
  logic [ROW_W-1:0] ram_rdata;
  logic [ROW_W-1:0] row_new;
  logic [WAY_W-1:0] wr_way;
  rht_res_t         res;
  logic [31:0]      bucket_ext;

  logic             accept;

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);

  // Bucket index by reciprocal multiply, then one subtract-correct step
  assign quot     = prod_q[31 +: SEQ_W];
  assign quot_mul = 32'(quot) * 32'(BUCKETS);
  assign rem_full = 32'(seq_q) - quot_mul;

  always_comb begin
    if (rem_q >= REM_W'(BUCKETS)) begin
      rem_fixed = BKT_W'(rem_q - REM_W'(BUCKETS));
    end else begin
      rem_fixed = BKT_W'(rem_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    ram_re    = 1'b0;
    ram_raddr = bucket_q;
    ram_we    = 1'b0;
    bucket_d  = bucket_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (POW2) begin
            bucket_d  = seq_num_i[BKT_W-1:0];
            ram_re    = 1'b1;
            ram_raddr = seq_num_i[BKT_W-1:0];
            state_d   = ST_EXEC;
          end else begin
            state_d = ST_DIV_MUL;
          end
        end
      end
      ST_DIV_MUL: begin
        state_d = ST_DIV_SUB;
      end
      ST_DIV_SUB: begin
        state_d = ST_DIV_FIX;
      end
      ST_DIV_FIX: begin
        bucket_d  = rem_fixed;
        ram_re    = 1'b1;
        ram_raddr = rem_fixed;
        state_d   = ST_EXEC;
      end
      ST_EXEC: begin
        ram_we  = (op_e'(op_q) == OP_INSERT);
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold the command word and the divider pipeline
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_i;
      seq_q <= seq_num_i;
      len_q <= payload_len_i;
    end
    bucket_q <= bucket_d;
    prod_q   <= PROD_W'(seq_q) * PROD_W'(RECIP);
    rem_q    <= REM_W'(rem_full);
  end

  rht_ram #(
    .WIDTH (ROW_W),
    .DEPTH (BUCKETS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (bucket_q),
    .wdata_i (row_new),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rht_row_logic #(
    .WAYS        (WAYS),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_row_logic (
    .op_i          (op_e'(op_q)),
    .seq_num_i     (seq_q),
    .payload_len_i (len_q),
    .row_i         (ram_rdata),
    .valid_i       (valid_q[bucket_q]),
    .res_o         (res),
    .row_o         (row_new),
    .wr_way_o      (wr_way)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < BUCKETS; b++) begin
        valid_q[b] <= '0;
      end
    end else if (ram_we) begin
      valid_q[bucket_q][wr_way] <= 1'b1;
    end
  end

  assign bucket_ext = 32'(bucket_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= (state_q == ST_EXEC);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EXEC) begin
      hit_o         <= res.hit;
      slot_bucket_o <= bucket_ext[BKT_OUT_W-1:0];
      slot_way_o    <= res.way;
      stored_len_o  <= res.len;
    end
  end

endmodule
